@@ src/oep_pkg.sv @@
// shared types, constants and register codes of the obstacle endpoint predictor
package oep_pkg;

    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int REG_W   = 31;
    localparam int N_CELLS = 31;

    // configuration register indexes
    localparam logic [1:0] CFG_PRED_TIME   = 2'd0;
    localparam logic [1:0] CFG_TIME_MARGIN = 2'd1;
    localparam logic [1:0] CFG_MIN_DET     = 2'd2;
    localparam logic [1:0] CFG_MIN_SPEED   = 2'd3;

    localparam logic [REG_W-1:0] PRED_TIME_RST   = 31'd262144;
    localparam logic [REG_W-1:0] TIME_MARGIN_RST = 31'd131072;
    localparam logic [REG_W-1:0] MIN_DET_RST     = 31'd66;
    localparam logic [REG_W-1:0] MIN_SPEED_RST   = 31'd66;

    localparam logic signed [WORD_W-1:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] SMIN = -32'sh7FFF_FFFF - 32'sd1;

    typedef struct packed {
        logic [REG_W-1:0]   pred;
        logic [REG_W-1:0]   margin;
        logic [REG_W-1:0]   min_det;
        logic [2*REG_W-1:0] ms2;
    } oep_cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] rx;
        logic signed [WORD_W-1:0] ry;
        logic signed [WORD_W-1:0] rvx;
        logic signed [WORD_W-1:0] rvy;
        logic                     pv;
        logic signed [WORD_W-1:0] tx;
        logic signed [WORD_W-1:0] ty;
        logic signed [WORD_W-1:0] tvx;
        logic signed [WORD_W-1:0] tvy;
    } oep_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] tx;
        logic signed [WORD_W-1:0] ty;
        logic signed [WORD_W-1:0] tvx;
        logic signed [WORD_W-1:0] tvy;
        logic                     inter;
        logic                     sat;
    } oep_side_t;

    typedef struct packed {
        logic [63:0]        rem;
        logic [N_CELLS-1:0] low;
        logic [63:0]        dv;
        logic [N_CELLS-1:0] quo;
        logic               ovf;
    } oep_div_t;

    typedef struct packed {
        oep_side_t side;
        oep_div_t  div;
    } oep_cell_t;

endpackage

@@ src/oep_front.sv @@
// front pipeline: products, determinant, crossing numerator and divider set-up
module oep_front import oep_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  oep_cfg_t  cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  oep_in_t   in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output oep_cell_t out_data
);

    typedef struct packed {
        logic signed [63:0]       p1;
        logic signed [63:0]       p2;
        logic signed [63:0]       sq1;
        logic signed [63:0]       sq2;
        logic signed [WORD_W-1:0] dx;
        logic signed [WORD_W-1:0] dy;
        logic                     sat;
        logic                     pv;
        logic signed [WORD_W-1:0] tx;
        logic signed [WORD_W-1:0] ty;
        logic signed [WORD_W-1:0] tvx;
        logic signed [WORD_W-1:0] tvy;
    } s2_t;

    typedef struct packed {
        logic signed [64:0]       dcross;
        logic [63:0]              sp2;
        logic signed [63:0]       n1;
        logic signed [63:0]       n2;
        logic                     sat;
        logic                     pv;
        logic signed [WORD_W-1:0] tx;
        logic signed [WORD_W-1:0] ty;
        logic signed [WORD_W-1:0] tvx;
        logic signed [WORD_W-1:0] tvy;
    } s3_t;

    typedef struct packed {
        logic [63:0]              an;
        logic [63:0]              dv;
        logic                     inter;
        logic                     sat;
        logic signed [WORD_W-1:0] tx;
        logic signed [WORD_W-1:0] ty;
        logic signed [WORD_W-1:0] tvx;
        logic signed [WORD_W-1:0] tvy;
    } s4_t;

    logic      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic      rdy1, rdy2, rdy3, rdy4, rdy5;
    oep_in_t   d1_reg;
    s2_t       d2_reg, d2_next;
    s3_t       d3_reg, d3_next;
    s4_t       d4_reg, d4_next;
    oep_cell_t d5_reg, d5_next;

    logic signed [WORD_W:0] dxw, dyw;
    logic signed [64:0]     num, nneg;
    logic                   det_low, spd_ok;

    // stall chain, a stage moves when empty or when the next one moves
    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 2: velocity products and clamped position difference
    always_comb begin
        dxw = $signed({d1_reg.tx[WORD_W-1], d1_reg.tx}) - $signed({d1_reg.rx[WORD_W-1], d1_reg.rx});
        dyw = $signed({d1_reg.ty[WORD_W-1], d1_reg.ty}) - $signed({d1_reg.ry[WORD_W-1], d1_reg.ry});
        d2_next.p1  = d1_reg.rvx * d1_reg.tvy;
        d2_next.p2  = d1_reg.rvy * d1_reg.tvx;
        d2_next.sq1 = d1_reg.rvx * d1_reg.rvx;
        d2_next.sq2 = d1_reg.rvy * d1_reg.rvy;
        d2_next.dx  = (dxw[WORD_W] != dxw[WORD_W-1]) ? (dxw[WORD_W] ? SMIN : SMAX)
                                                      : dxw[WORD_W-1:0];
        d2_next.dy  = (dyw[WORD_W] != dyw[WORD_W-1]) ? (dyw[WORD_W] ? SMIN : SMAX)
                                                      : dyw[WORD_W-1:0];
        d2_next.sat = (dxw[WORD_W] != dxw[WORD_W-1]) || (dyw[WORD_W] != dyw[WORD_W-1]);
        d2_next.pv  = d1_reg.pv;
        d2_next.tx  = d1_reg.tx;
        d2_next.ty  = d1_reg.ty;
        d2_next.tvx = d1_reg.tvx;
        d2_next.tvy = d1_reg.tvy;
    end

    // stage 3: determinant, squared speed, numerator products
    always_comb begin
        d3_next.dcross = $signed({d2_reg.p1[63], d2_reg.p1}) - $signed({d2_reg.p2[63], d2_reg.p2});
        d3_next.sp2    = d2_reg.sq1[63:0] + d2_reg.sq2[63:0];
        d3_next.n1     = d2_reg.dx * d2_reg.tvy;
        d3_next.n2     = d2_reg.dy * d2_reg.tvx;
        d3_next.sat    = d2_reg.sat;
        d3_next.pv     = d2_reg.pv;
        d3_next.tx     = d2_reg.tx;
        d3_next.ty     = d2_reg.ty;
        d3_next.tvx    = d2_reg.tvx;
        d3_next.tvy    = d2_reg.tvy;
    end

    // stage 4: fallback decision and numerator magnitude
    always_comb begin
        num     = $signed({d3_reg.n1[63], d3_reg.n1}) - $signed({d3_reg.n2[63], d3_reg.n2});
        nneg    = -num;
        det_low = (d3_reg.dcross <= 65'sd0) ||
                  (d3_reg.dcross < $signed({18'b0, cfg.min_det, 16'b0}));
        spd_ok  = d3_reg.sp2 >= {2'b0, cfg.ms2};
        d4_next.an    = num[64] ? nneg[63:0] : num[63:0];
        d4_next.dv    = d3_reg.dcross[63:0];
        d4_next.inter = d3_reg.pv && !det_low && spd_ok;
        d4_next.sat   = d3_reg.pv && !det_low && spd_ok && d3_reg.sat;
        d4_next.tx    = d3_reg.tx;
        d4_next.ty    = d3_reg.ty;
        d4_next.tvx   = d3_reg.tvx;
        d4_next.tvy   = d3_reg.tvy;
    end

    // stage 5: quotient overflow test and first partial remainder
    always_comb begin
        d5_next.side.tx    = d4_reg.tx;
        d5_next.side.ty    = d4_reg.ty;
        d5_next.side.tvx   = d4_reg.tvx;
        d5_next.side.tvy   = d4_reg.tvy;
        d5_next.side.inter = d4_reg.inter;
        d5_next.side.sat   = d4_reg.sat;
        d5_next.div.ovf    = {15'b0, d4_reg.an} >= {d4_reg.dv, 15'b0};
        d5_next.div.rem    = {15'b0, d4_reg.an[63:15]};
        d5_next.div.low    = {d4_reg.an[14:0], 16'b0};
        d5_next.div.dv     = d4_reg.dv;
        d5_next.div.quo    = '0;
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) d1_reg <= in_data;
        if (rdy2 && v1_reg)   d2_reg <= d2_next;
        if (rdy3 && v2_reg)   d3_reg <= d3_next;
        if (rdy4 && v3_reg)   d4_reg <= d4_next;
        if (rdy5 && v4_reg)   d5_reg <= d5_next;
    end

    assign out_valid = v5_reg;
    assign out_data  = d5_reg;

endmodule

@@ src/oep_cell.sv @@
// one restoring division cell: one quotient bit per cell
module oep_cell import oep_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  oep_cell_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output oep_cell_t out_data
);

    logic      v_reg;
    oep_cell_t d_reg, d_next;
    logic [64:0] pr, dvx, diff;
    logic        ge;

    assign in_ready = !v_reg || out_ready;

    // shift in the next dividend bit, compare and subtract
    always_comb begin
        pr   = {in_data.div.rem, in_data.div.low[N_CELLS-1]};
        dvx  = {1'b0, in_data.div.dv};
        diff = pr - dvx;
        ge   = pr >= dvx;
        d_next          = in_data;
        d_next.div.rem  = ge ? diff[63:0] : pr[63:0];
        d_next.div.low  = {in_data.div.low[N_CELLS-2:0], 1'b0};
        d_next.div.quo  = {in_data.div.quo[N_CELLS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

@@ src/oep_back.sv @@
// back pipeline: horizon select, extrapolation and clamped output register
module oep_back import oep_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  oep_cfg_t           cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  oep_cell_t          in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [WORD_W-1:0]  end_x,
    output logic [WORD_W-1:0]  end_y,
    output logic               used_inter,
    output logic               sat_flag
);

    typedef struct packed {
        logic [WORD_W-1:0] t;
        oep_side_t         side;
    } b1_t;

    typedef struct packed {
        logic signed [64:0] px;
        logic signed [64:0] py;
        oep_side_t          side;
    } b2_t;

    logic b1v_reg, b2v_reg, ov_reg;
    logic rdy1, rdy2, rdy3;
    b1_t  b1_reg, b1_next;
    b2_t  b2_reg, b2_next;
    logic [N_CELLS-1:0] s;
    logic signed [65:0] sx, sy;
    logic signed [WORD_W-1:0] ex_next, ey_next;
    logic sat_next;
    logic [WORD_W-1:0] ex_reg, ey_reg;
    logic inter_reg, sat_reg;

    assign rdy3     = !ov_reg || out_ready;
    assign rdy2     = !b2v_reg || rdy3;
    assign rdy1     = !b1v_reg || rdy2;
    assign in_ready = rdy1;

    // horizon: crossing time plus margin, or the fixed horizon
    always_comb begin
        s = in_data.div.ovf ? {N_CELLS{1'b1}} : in_data.div.quo;
        b1_next.t = in_data.side.inter ? ({1'b0, s} + {1'b0, cfg.margin}) : {1'b0, cfg.pred};
        b1_next.side = in_data.side;
        b1_next.side.sat = in_data.side.sat || (in_data.side.inter && in_data.div.ovf);
    end

    // horizon times velocity
    always_comb begin
        b2_next.px   = $signed({1'b0, b1_reg.t}) * b1_reg.side.tvx;
        b2_next.py   = $signed({1'b0, b1_reg.t}) * b1_reg.side.tvy;
        b2_next.side = b1_reg.side;
    end

    // floor shift, add position, clamp
    always_comb begin
        sx = (b2_reg.px >>> FRAC_W) + b2_reg.side.tx;
        sy = (b2_reg.py >>> FRAC_W) + b2_reg.side.ty;
        sat_next = b2_reg.side.sat;
        if (sx > SMAX) begin
            ex_next = SMAX;
            sat_next = 1'b1;
        end else if (sx < SMIN) begin
            ex_next = SMIN;
            sat_next = 1'b1;
        end else begin
            ex_next = sx[WORD_W-1:0];
        end
        if (sy > SMAX) begin
            ey_next = SMAX;
            sat_next = 1'b1;
        end else if (sy < SMIN) begin
            ey_next = SMIN;
            sat_next = 1'b1;
        end else begin
            ey_next = sy[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1v_reg <= 1'b0;
            b2v_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end else begin
            if (rdy1) b1v_reg <= in_valid;
            if (rdy2) b2v_reg <= b1v_reg;
            if (rdy3) ov_reg  <= b2v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) b1_reg <= b1_next;
        if (rdy2 && b1v_reg)  b2_reg <= b2_next;
        if (rdy3 && b2v_reg) begin
            ex_reg    <= ex_next;
            ey_reg    <= ey_next;
            inter_reg <= b2_reg.side.inter;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid  = ov_reg;
    assign end_x      = ex_reg;
    assign end_y      = ey_reg;
    assign used_inter = inter_reg;
    assign sat_flag   = sat_reg;

endmodule

@@ src/obstacle_endpoint_predictor.sv @@
// path: an accepted input transaction passes the front pipeline, cell chain and back pipeline to the m_ side
// throughput: one transaction per cycle while m_tready holds, a 31-cell restoring divider chain with one
// quotient bit per cell sets the pipeline depth
// ready is combinational through every stage, a bubble anywhere keeps input flowing
// reset: synchronous active-low aresetn empties every stage and loads register defaults
// top level: configuration registers, front pipeline, divider cell chain, back pipeline
module obstacle_endpoint_predictor import oep_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [30:0]  cfg_wdata,
    // input transactions
    input  logic         s_tvalid,
    output logic         s_tready,
    // robot_x, robot_y, robot_vx, robot_vy, track_x, track_y, track_vx, track_vy
    input  logic [255:0] s_tdata,
    // pose_valid
    input  logic [0:0]   s_tuser,
    // result transactions
    output logic         m_tvalid,
    input  logic         m_tready,
    // end_x, end_y
    output logic [63:0]  m_tdata,
    // used_intersection, saturated
    output logic [1:0]   m_tuser
);

    logic [REG_W-1:0]   pred_reg, margin_reg, mindet_reg, minspd_reg;
    logic [2*REG_W-1:0] ms2_reg;
    oep_cfg_t cfg;
    oep_in_t  in_data;

    logic      cv [N_CELLS+1];
    logic      cr [N_CELLS+1];
    oep_cell_t cd [N_CELLS+1];

    logic [WORD_W-1:0] end_x, end_y;
    logic used_inter, sat_flag;

    // configuration registers, squared speed limit kept alongside
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pred_reg   <= PRED_TIME_RST;
            margin_reg <= TIME_MARGIN_RST;
            mindet_reg <= MIN_DET_RST;
            minspd_reg <= MIN_SPEED_RST;
            ms2_reg    <= MIN_SPEED_RST * MIN_SPEED_RST;
        end else begin
            ms2_reg <= minspd_reg * minspd_reg;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_PRED_TIME:   pred_reg   <= cfg_wdata;
                    CFG_TIME_MARGIN: margin_reg <= cfg_wdata;
                    CFG_MIN_DET:     mindet_reg <= cfg_wdata;
                    CFG_MIN_SPEED:   minspd_reg <= cfg_wdata;
                    default:         pred_reg   <= pred_reg;
                endcase
            end
        end
    end

    assign cfg.pred    = pred_reg;
    assign cfg.margin  = margin_reg;
    assign cfg.min_det = mindet_reg;
    assign cfg.ms2     = ms2_reg;

    // unpack the input transaction
    assign in_data.rx  = s_tdata[31:0];
    assign in_data.ry  = s_tdata[63:32];
    assign in_data.rvx = s_tdata[95:64];
    assign in_data.rvy = s_tdata[127:96];
    assign in_data.tx  = s_tdata[159:128];
    assign in_data.ty  = s_tdata[191:160];
    assign in_data.tvx = s_tdata[223:192];
    assign in_data.tvy = s_tdata[255:224];
    assign in_data.pv  = s_tuser[0];

    oep_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_data),
        .out_valid (cv[0]),
        .out_ready (cr[0]),
        .out_data  (cd[0])
    );

    // divider cell chain
    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
        oep_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .in_data   (cd[i]),
            .out_valid (cv[i+1]),
            .out_ready (cr[i+1]),
            .out_data  (cd[i+1])
        );
    end

    oep_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (cv[N_CELLS]),
        .in_ready   (cr[N_CELLS]),
        .in_data    (cd[N_CELLS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .end_x      (end_x),
        .end_y      (end_y),
        .used_inter (used_inter),
        .sat_flag   (sat_flag)
    );

    assign m_tdata = {end_y, end_x};
    assign m_tuser = {sat_flag, used_inter};

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a free output stage means the whole pipeline can move
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with free output");

    // in fallback the saturated flag only comes from clamped end coordinates
    a_fallback_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1] && !m_tuser[0]) |->
        (m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
         m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000))
        else $error("fallback saturation without clamped end");

endmodule
